// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds on every rising clock edge outside reset.
`define TBDF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// Assert that a condition never holds on a rising clock edge outside reset.
`define TBDF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `TBDF_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// File: rtl/tbdf_pkg.sv
// Package with constants, types and codes of the thumbnail downscaler.
`default_nettype none

package tbdf_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int THUMB_WIDTH = 192;

  localparam int DIM_W    = 10;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int SUM_W    = CHAN_W + 2;
  localparam int OUT_X_W  = 8;
  localparam int ROWS_W   = 17;
  localparam int DVD_W    = 26;
  localparam int DVS_W    = ROWS_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = '1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic CFG_SRC_WIDTH  = 1'b0;
  localparam logic CFG_SRC_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    DIV_ROWS = 2'd0,
    DIV_SY   = 2'd1,
    DIV_HR   = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic       mem_we;
    logic       latch_in;
    logic       div_start;
    div_sel_e   div_sel;
    logic       save_rows;
    logic       save_prod;
    logic       save_sx;
    logic       save_sy;
    logic       save_hr;
    logic       acc_clr;
    logic       mem_rd;
    logic [1:0] sample_idx;
    logic       emit;
    logic       emit_oor;
  } tbdf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic row_oor;
  } tbdf_status_t;

endpackage

`default_nettype wire

// File: rtl/tbdf_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module tbdf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tbdf_pkg::DVD_W-1:0] dividend_i,
  input  logic [tbdf_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [tbdf_pkg::DVD_W-1:0] quotient_o
);
  import tbdf_pkg::*;

  logic                 active_q, active_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W:0]       rem_sh;
  logic [DVS_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      quo_d    = dividend_i;
      rem_d    = '0;
      dvs_d    = divisor_i;
    end else if (active_q) begin
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/tbdf_dp.sv
// Datapath with configuration registers, frame store, divider and averaging.
`default_nettype none

module tbdf_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tbdf_pkg::tbdf_cmd_t             cmd_i,
  output tbdf_pkg::tbdf_status_t          status_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [tbdf_pkg::DIM_W-1:0]      cfg_wdata_i,
  input  logic [tbdf_pkg::COL_W-1:0]      src_x_i,
  input  logic [tbdf_pkg::ROW_W-1:0]      src_y_i,
  input  logic [tbdf_pkg::CHAN_W-1:0]     red_in_i,
  input  logic [tbdf_pkg::CHAN_W-1:0]     green_in_i,
  input  logic [tbdf_pkg::CHAN_W-1:0]     blue_in_i,
  input  logic [tbdf_pkg::OUT_X_W-1:0]    out_x_i,
  input  logic [tbdf_pkg::ROWS_W-1:0]     out_y_i,
  output logic                            done_o,
  output logic [tbdf_pkg::CHAN_W-1:0]     red_out_o,
  output logic [tbdf_pkg::CHAN_W-1:0]     green_out_o,
  output logic [tbdf_pkg::CHAN_W-1:0]     blue_out_o,
  output logic [tbdf_pkg::CHAN_W-1:0]     alpha_out_o,
  output logic [tbdf_pkg::ROWS_W-1:0]     thumb_rows_o,
  output logic                            row_out_of_range_o
);
  import tbdf_pkg::*;

  localparam logic [DIM_W-1:0]   MaxW     = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]   MaxH     = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0]   StepTwoW = DIM_W'(2 * THUMB_WIDTH);
  localparam logic [OUT_X_W-1:0] LastX    = OUT_X_W'(THUMB_WIDTH - 1);

  // The thumbnail width is an odd factor times 64, so the source column is a shift
  // followed by a multiply with the rounded-up reciprocal of that factor.
  localparam int ThumbShift = 6;
  localparam int ThumbOdd   = THUMB_WIDTH >> ThumbShift;
  localparam int RecipShift = 17;
  localparam logic [RecipShift-1:0] RecipOdd =
      RecipShift'((2 ** RecipShift + ThumbOdd - 1) / ThumbOdd);
  localparam int SxProdW    = OUT_X_W + DIM_W;

  logic [DIM_W-1:0]   width_q, height_q;
  logic [DIM_W-1:0]   w, h;
  logic [OUT_X_W-1:0] x_q;
  logic [ROWS_W-1:0]  y_q;
  logic [ROWS_W-1:0]  rows_q;
  logic [SxProdW-1:0] prod_sx_q;
  logic [DVD_W-1:0]   prod_sy_q;
  logic [SxProdW-ThumbShift+RecipShift-1:0] sx_mul;
  logic [ROWS_W-1:0]  rows_left;
  logic [ROWS_W+DIM_W-1:0] prod_sy_full;
  logic [DIM_W-1:0]   sx_q, sy_q, hr_q;
  logic [DIM_W:0]     sx_inc, sy_inc;
  logic [DIM_W-1:0]   sx2, sy2;
  logic [DIM_W-1:0]   col_sel, row_sel;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic               div_done;
  logic [DVD_W-1:0]   div_quo;
  logic [PIX_W-1:0]   mem [DEPTH];
  logic [PIX_W-1:0]   rdata_q;
  logic               rd_valid_q;
  logic [SUM_W-1:0]   acc_r_q, acc_g_q, acc_b_q;
  logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
  logic               done_q;
  logic [CHAN_W-1:0]  red_q, green_q, blue_q, alpha_q;
  logic [ROWS_W-1:0]  thumb_rows_q;
  logic               oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SRC_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w = DIM_W'(1);
    end else if (width_q > MaxW) begin
      w = MaxW;
    end else begin
      w = width_q;
    end
    if (height_q == '0) begin
      h = DIM_W'(1);
    end else if (height_q > MaxH) begin
      h = MaxH;
    end else begin
      h = height_q;
    end
  end

  assign rows_left    = rows_q - ROWS_W'(1) - y_q;
  assign prod_sy_full = rows_left * h;

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_ROWS: begin
        dvd = DVD_W'(h) * DVD_W'(THUMB_WIDTH);
        dvs = DVS_W'(w);
      end
      DIV_SY: begin
        dvd = prod_sy_q;
        dvs = rows_q;
      end
      DIV_HR: begin
        dvd = DVD_W'(h);
        dvs = rows_q;
      end
      default: begin
        dvd = '0;
        dvs = DVS_W'(1);
      end
    endcase
  end

  tbdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign sx_mul = prod_sx_q[SxProdW-1:ThumbShift] * RecipOdd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      x_q <= (out_x_i > LastX) ? LastX : out_x_i;
      y_q <= out_y_i;
    end
    if (cmd_i.save_rows) begin
      rows_q <= (div_quo[ROWS_W-1:0] == '0) ? ROWS_W'(1) : div_quo[ROWS_W-1:0];
    end
    if (cmd_i.save_prod) begin
      prod_sx_q <= SxProdW'(x_q) * SxProdW'(w);
      prod_sy_q <= prod_sy_full[DVD_W-1:0];
    end
    if (cmd_i.save_sx) begin
      sx_q <= sx_mul[RecipShift +: DIM_W];
    end
    if (cmd_i.save_sy) begin
      sy_q <= div_quo[DIM_W-1:0];
    end
    if (cmd_i.save_hr) begin
      hr_q <= div_quo[DIM_W-1:0];
    end
  end

  assign sx_inc = {1'b0, sx_q} + ((w >= StepTwoW) ? (DIM_W + 1)'(1) : '0);
  assign sy_inc = {1'b0, sy_q} + {2'b0, hr_q[DIM_W-1:1]};
  assign sx2    = (sx_inc > {1'b0, w - DIM_W'(1)}) ? (w - DIM_W'(1)) : sx_inc[DIM_W-1:0];
  assign sy2    = (sy_inc > {1'b0, h - DIM_W'(1)}) ? (h - DIM_W'(1)) : sy_inc[DIM_W-1:0];

  assign col_sel = cmd_i.sample_idx[0] ? sx2 : sx_q;
  assign row_sel = cmd_i.sample_idx[1] ? sy2 : sy_q;
  assign rd_addr = {row_sel[ROW_W-1:0], col_sel[COL_W-1:0]};
  assign wr_addr = {src_y_i, src_x_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[wr_addr] <= {red_in_i, green_in_i, blue_in_i};
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign sum_r = acc_r_q + SUM_W'(rdata_q[3*CHAN_W-1:2*CHAN_W]);
  assign sum_g = acc_g_q + SUM_W'(rdata_q[2*CHAN_W-1:CHAN_W]);
  assign sum_b = acc_b_q + SUM_W'(rdata_q[CHAN_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.mem_rd;
      done_q     <= cmd_i.emit | cmd_i.emit_oor;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
    end else if (rd_valid_q) begin
      acc_r_q <= sum_r;
      acc_g_q <= sum_g;
      acc_b_q <= sum_b;
    end
    if (cmd_i.emit) begin
      red_q        <= sum_r[SUM_W-1:2];
      green_q      <= sum_g[SUM_W-1:2];
      blue_q       <= sum_b[SUM_W-1:2];
      alpha_q      <= ALPHA_OPAQUE;
      thumb_rows_q <= rows_q;
      oor_q        <= 1'b0;
    end else if (cmd_i.emit_oor) begin
      red_q        <= '0;
      green_q      <= '0;
      blue_q       <= '0;
      alpha_q      <= '0;
      thumb_rows_q <= rows_q;
      oor_q        <= 1'b1;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.row_oor  = (y_q >= rows_q);

  assign done_o             = done_q;
  assign red_out_o          = red_q;
  assign green_out_o        = green_q;
  assign blue_out_o         = blue_q;
  assign alpha_out_o        = alpha_q;
  assign thumb_rows_o       = thumb_rows_q;
  assign row_out_of_range_o = oor_q;

endmodule

`default_nettype wire

// File: rtl/tbdf_ctrl.sv
// Controller state machine that sequences loads, divisions and sample reads.
`default_nettype none

module tbdf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   cmd_i,
  input  tbdf_pkg::tbdf_status_t status_i,
  output tbdf_pkg::tbdf_cmd_t    cmd_o,
  output logic                   busy
);
  import tbdf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DROWS = 8'b00000010,
    S_CHECK = 8'b00000100,
    S_PROD  = 8'b00001000,
    S_DSY   = 8'b00010000,
    S_DHR   = 8'b00100000,
    S_READ  = 8'b01000000,
    S_LAST  = 8'b10000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.div_sel    = DIV_ROWS;
    cmd_o.sample_idx = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_READ) begin
            cmd_o.latch_in  = 1'b1;
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_ROWS;
            state_d         = S_DROWS;
          end else begin
            cmd_o.mem_we = 1'b1;
          end
        end
      end
      S_DROWS: begin
        if (status_i.div_done) begin
          cmd_o.save_rows = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.row_oor) begin
          cmd_o.emit_oor = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.save_prod = 1'b1;
          state_d         = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.save_sx   = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SY;
        state_d         = S_DSY;
      end
      S_DSY: begin
        if (status_i.div_done) begin
          cmd_o.save_sy   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_HR;
          state_d         = S_DHR;
        end
      end
      S_DHR: begin
        if (status_i.div_done) begin
          cmd_o.save_hr = 1'b1;
          cmd_o.acc_clr = 1'b1;
          cnt_d         = '0;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        cnt_d        = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/thumbnail_box_downscale_flip_unit.sv
// Top level of the thumbnail box downscaler with vertical flip.
// A load word is written to the frame store at its accepting edge, gives no result and can be
// followed by another word in the next cycle. A read beyond the thumbnail height strobes its
// result after one divider pass and the row check, an in-range read after three 26-step divider
// passes and four frame store reads; busy falls with the strobe, so no new read is taken before
// the last one's result. Reset clears control and sets both frame dimensions to 1, not the store.
`default_nettype none

module thumbnail_box_downscale_flip_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd_i,
  input  logic [tbdf_pkg::COL_W-1:0]      src_x_i,
  input  logic [tbdf_pkg::ROW_W-1:0]      src_y_i,
  input  logic [tbdf_pkg::CHAN_W-1:0]     red_in_i,
  input  logic [tbdf_pkg::CHAN_W-1:0]     green_in_i,
  input  logic [tbdf_pkg::CHAN_W-1:0]     blue_in_i,
  input  logic [tbdf_pkg::OUT_X_W-1:0]    out_x_i,
  input  logic [tbdf_pkg::ROWS_W-1:0]     out_y_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [tbdf_pkg::DIM_W-1:0]      cfg_wdata_i,
  output logic                            done_o,
  output logic [tbdf_pkg::CHAN_W-1:0]     red_out_o,
  output logic [tbdf_pkg::CHAN_W-1:0]     green_out_o,
  output logic [tbdf_pkg::CHAN_W-1:0]     blue_out_o,
  output logic [tbdf_pkg::CHAN_W-1:0]     alpha_out_o,
  output logic [tbdf_pkg::ROWS_W-1:0]     thumb_rows_o,
  output logic                            row_out_of_range_o
);
  import tbdf_pkg::*;

  tbdf_cmd_t    cmd;
  tbdf_status_t status;

  tbdf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  tbdf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .src_x_i            (src_x_i),
    .src_y_i            (src_y_i),
    .red_in_i           (red_in_i),
    .green_in_i         (green_in_i),
    .blue_in_i          (blue_in_i),
    .out_x_i            (out_x_i),
    .out_y_i            (out_y_i),
    .done_o             (done_o),
    .red_out_o          (red_out_o),
    .green_out_o        (green_out_o),
    .blue_out_o         (blue_out_o),
    .alpha_out_o        (alpha_out_o),
    .thumb_rows_o       (thumb_rows_o),
    .row_out_of_range_o (row_out_of_range_o)
  );

endmodule

`default_nettype wire

// File: rtl/tbdf_checker.sv
// Port-level checker for the thumbnail downscaler and its bind statement.
`default_nettype none

`include "assert_macros.svh"

module tbdf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        cmd_i,
  input logic                        done_o,
  input logic [tbdf_pkg::CHAN_W-1:0] red_out_o,
  input logic [tbdf_pkg::CHAN_W-1:0] alpha_out_o,
  input logic                        row_out_of_range_o
);
  import tbdf_pkg::*;

  `TBDF_ASSERT(a_read_sets_busy, clk_i, rst_ni, start && !busy && cmd_i == CMD_READ |=> busy)
  `TBDF_ASSERT_NEVER(a_load_no_result, clk_i, rst_ni, $past(start && !busy && cmd_i == CMD_LOAD) && done_o)
  `TBDF_ASSERT_NEVER(a_result_while_busy, clk_i, rst_ni, done_o && busy)
  `TBDF_ASSERT(a_oor_zero, clk_i, rst_ni, done_o && row_out_of_range_o |-> red_out_o == '0 && alpha_out_o == '0)
  `TBDF_ASSERT(a_valid_alpha, clk_i, rst_ni, done_o && !row_out_of_range_o |-> alpha_out_o == ALPHA_OPAQUE)

endmodule

bind thumbnail_box_downscale_flip_unit tbdf_checker u_tbdf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .cmd_i              (cmd_i),
  .done_o             (done_o),
  .red_out_o          (red_out_o),
  .alpha_out_o        (alpha_out_o),
  .row_out_of_range_o (row_out_of_range_o)
);

`default_nettype wire
